// ===== sv/mpd_pkg.sv =====
// Shared types and constants for the MQTT publish deframer.
// Used by mpd_step and mqtt_publish_deframer_unit; no dependencies.
package mpd_pkg;

  localparam int MAX_LENGTH_BYTES_DEF = 4;
  localparam int REC_W                = 16;
  localparam int BODY_W               = 28;
  localparam int CNT_W                = 3;
  localparam int TOPIC_W              = 16;

  typedef enum logic [2:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_HEADER,
    PH_VARINT,
    PH_TLEN,
    PH_TOPIC,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_VARINT_LONG,
    ST_TOPIC_OVERRUN,
    ST_RECORD_OVERRUN
  } status_t;

  typedef struct packed {
    phase_t               phase;
    logic [REC_W-1:0]     record_left;
    logic [BODY_W-1:0]    body_left;
    logic [CNT_W-1:0]     len_cnt;
    logic [TOPIC_W-1:0]   topic_left;
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       empty;
    status_t    status;
  } result_t;

endpackage

// ===== sv/mpd_step.sv =====
// Per-beat parser step: next parser state and optional result for one record byte.
// Depends on mpd_pkg.
module mpd_step #(
  parameter int MAX_LENGTH_BYTES = mpd_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  mpd_pkg::state_t  cur,
  input  logic [7:0]       in_byte,
  output mpd_pkg::state_t  nxt,
  output mpd_pkg::result_t res
);
  import mpd_pkg::*;

  logic [REC_W-1:0]   rec_dec;
  logic [BODY_W-1:0]  body_dec;
  logic [TOPIC_W-1:0] topic_dec;
  logic [TOPIC_W-1:0] topic_full;
  logic [REC_W-1:0]   rec_full;
  logic [BODY_W-1:0]  group;
  logic [BODY_W-1:0]  body_acc;
  logic [CNT_W-1:0]   cnt_inc;
  phase_t             fail_phase;
  phase_t             done_phase;

  always_comb begin
    rec_dec    = cur.record_left - 1'b1;
    body_dec   = cur.body_left - 1'b1;
    topic_dec  = cur.topic_left - 1'b1;
    topic_full = cur.topic_left | {8'h00, in_byte};
    rec_full   = cur.record_left | {8'h00, in_byte};
    cnt_inc    = cur.len_cnt + 1'b1;
    fail_phase = (rec_dec == '0) ? PH_LEN_HI : PH_DISCARD;
    done_phase = (rec_dec == '0) ? PH_LEN_HI : PH_HEADER;
    case (cur.len_cnt)
      3'd0:    group = {21'b0, in_byte[6:0]};
      3'd1:    group = {14'b0, in_byte[6:0], 7'b0};
      3'd2:    group = {7'b0, in_byte[6:0], 14'b0};
      3'd3:    group = {in_byte[6:0], 21'b0};
      default: group = '0;
    endcase
    body_acc = cur.body_left | group;
  end

  always_comb begin
    nxt        = cur;
    res.valid  = 1'b0;
    res.data   = 8'h00;
    res.last   = 1'b0;
    res.empty  = 1'b0;
    res.status = ST_OK;
    case (cur.phase)
      PH_LEN_HI: begin
        nxt.record_left = {in_byte, 8'h00};
        nxt.phase       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        nxt.record_left = rec_full;
        nxt.phase       = (rec_full == '0) ? PH_LEN_HI : PH_HEADER;
      end
      PH_HEADER: begin
        nxt.record_left = rec_dec;
        nxt.body_left   = '0;
        nxt.len_cnt     = '0;
        if (rec_dec == '0) begin
          nxt.phase  = PH_LEN_HI;
          res.valid  = 1'b1;
          res.status = ST_RECORD_OVERRUN;
        end else begin
          nxt.phase = PH_VARINT;
        end
      end
      PH_VARINT: begin
        nxt.record_left = rec_dec;
        nxt.body_left   = body_acc;
        nxt.len_cnt     = cnt_inc;
        if (in_byte[7]) begin
          if (cnt_inc >= CNT_W'(MAX_LENGTH_BYTES)) begin
            nxt.phase  = fail_phase;
            res.valid  = 1'b1;
            res.status = ST_VARINT_LONG;
          end else if (rec_dec == '0) begin
            nxt.phase  = fail_phase;
            res.valid  = 1'b1;
            res.status = ST_RECORD_OVERRUN;
          end
        end else if (body_acc > BODY_W'(rec_dec)) begin
          nxt.phase  = fail_phase;
          res.valid  = 1'b1;
          res.status = ST_RECORD_OVERRUN;
        end else if (body_acc < BODY_W'(2)) begin
          nxt.phase  = fail_phase;
          res.valid  = 1'b1;
          res.status = ST_TOPIC_OVERRUN;
        end else begin
          nxt.len_cnt    = '0;
          nxt.topic_left = '0;
          nxt.phase      = PH_TLEN;
        end
      end
      PH_TLEN: begin
        nxt.record_left = rec_dec;
        nxt.body_left   = body_dec;
        if (cur.len_cnt == '0) begin
          nxt.topic_left = {in_byte, 8'h00};
          nxt.len_cnt    = CNT_W'(1);
        end else begin
          nxt.topic_left = topic_full;
          if (BODY_W'(topic_full) > body_dec) begin
            nxt.phase  = fail_phase;
            res.valid  = 1'b1;
            res.status = ST_TOPIC_OVERRUN;
          end else if (topic_full != '0) begin
            nxt.phase = PH_TOPIC;
          end else if (body_dec == '0) begin
            nxt.phase = done_phase;
            res.valid = 1'b1;
            res.last  = 1'b1;
            res.empty = 1'b1;
          end else begin
            nxt.phase = PH_PAYLOAD;
          end
        end
      end
      PH_TOPIC: begin
        nxt.record_left = rec_dec;
        nxt.body_left   = body_dec;
        nxt.topic_left  = topic_dec;
        if (topic_dec == '0) begin
          if (body_dec == '0) begin
            nxt.phase = done_phase;
            res.valid = 1'b1;
            res.last  = 1'b1;
            res.empty = 1'b1;
          end else begin
            nxt.phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        nxt.record_left = rec_dec;
        nxt.body_left   = body_dec;
        res.valid       = 1'b1;
        res.data        = in_byte;
        if (body_dec == '0) begin
          res.last  = 1'b1;
          nxt.phase = done_phase;
        end
      end
      default: begin
        nxt.record_left = rec_dec;
        if (rec_dec == '0) begin
          nxt.phase = PH_LEN_HI;
        end
      end
    endcase
  end

endmodule

// ===== sv/mqtt_publish_deframer_unit.sv =====
// MQTT QoS0 PUBLISH deframer: takes one record byte per beat and returns payload beats.
// The block accepts one byte per clock cycle when the result side keeps up; each byte
// passes through an input register and then a result register. The pace is set only
// by the result register: a held result stalls the input once the input register is
// also full. Malformed records give one error beat and the rest of the record is
// dropped. Depends on mpd_pkg and mpd_step.
module mqtt_publish_deframer_unit #(
  parameter int MAX_LENGTH_BYTES = mpd_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic       out_last_of_message,
  output logic       out_empty_message,
  output logic [1:0] out_status
);
  import mpd_pkg::*;

  state_t     state_r, state_nxt, step_state;
  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;
  result_t    out_r, out_nxt, step_res;
  logic       advance;

  mpd_step #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_step (
    .cur     (state_r),
    .in_byte (in_byte_r),
    .nxt     (step_state),
    .res     (step_res)
  );

  always_comb begin
    advance   = in_v_r && (!out_r.valid || out_ready);
    in_ready  = !in_v_r || advance;
    state_nxt = advance ? step_state : state_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end else begin
      in_v_nxt = in_v_r;
    end
    out_nxt = out_r;
    if (advance) begin
      out_nxt = step_res;
    end else if (out_ready) begin
      out_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_LEN_HI;
      state_r.record_left <= '0;
      state_r.body_left   <= '0;
      state_r.len_cnt     <= '0;
      state_r.topic_left  <= '0;
      in_v_r              <= 1'b0;
      out_r.valid         <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_v_r      <= in_v_nxt;
      out_r.valid <= out_nxt.valid;
    end
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    out_r.data   <= out_nxt.data;
    out_r.last   <= out_nxt.last;
    out_r.empty  <= out_nxt.empty;
    out_r.status <= out_nxt.status;
  end

  assign out_valid           = out_r.valid;
  assign out_payload_byte    = out_r.data;
  assign out_last_of_message = out_r.last;
  assign out_empty_message   = out_r.empty;
  assign out_status          = out_r.status;

  a_err_unmarked: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && out_r.status != ST_OK |-> !out_r.last && !out_r.empty && out_r.data == 8'h00)
    else $error("error beat carries message marks");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && out_r.empty |-> out_r.last && out_r.data == 8'h00)
    else $error("empty marker not flagged last");

  a_discard_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_DISCARD |-> state_r.record_left != '0)
    else $error("discard with nothing left in record");

  a_topic_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_TOPIC |-> state_r.topic_left != '0)
    else $error("topic skip with zero topic bytes");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && !out_ready && in_v_r |=> $stable(state_r))
    else $error("parser state moved while result stalled");

endmodule
